FILE: rtl/core/tdcp_pkg.sv
// Package for the text display command port.
// Holds command codes, sequencer states and character constants; no dependencies.
package tdcp_pkg;

  // Command codes carried in the command field of a request.
  typedef enum logic [7:0] {
    CMD_GET_MODE = 8'd0,
    CMD_SET_MODE = 8'd1,
    CMD_GET_POS  = 8'd2,
    CMD_SET_HIGH = 8'd3,
    CMD_SET_LOW  = 8'd4,
    CMD_GET_CHAR = 8'd5,
    CMD_SET_CHAR = 8'd6,
    CMD_SCROLL   = 8'd7
  } cmd_e;

  // Sequencer states of the display core.
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCR_RD,
    ST_SCR_WR
  } state_e;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

endpackage

FILE: rtl/core/tdcp_ifs.sv
// Valid/ready channel interfaces for the text display command port.
// Depends on nothing; used by the top level and its bind.
interface tdcp_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] data;
  logic [1:0] source_port;

  modport source (output valid, command, data, source_port, input ready);
  modport sink   (input valid, command, data, source_port, output ready);
endinterface

interface tdcp_reply_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_port;
  logic [15:0] reply_value;

  modport source (output valid, reply_port, reply_value, input ready);
  modport sink   (input valid, reply_port, reply_value, output ready);
endinterface

FILE: rtl/core/text_display_command_port.sv
// Mode and position reads reply in the next cycle; an in-range character read replies
// via the registered store read, then the reply register. One request is taken per
// cycle while the reply is free; a character read holds off the next until it replies.
// A scroll moves rows up one and blanks the last row, taking no request. Reset clears
// cursor and flag at once, then a clearing pass writes spaces to all CELLS cells, one
// per cycle, before the first request is accepted. Depends on tdcp_pkg, tdcp_ifs.
module text_display_command_port
  import tdcp_pkg::*;
#(
  parameter int unsigned COLUMNS = 30,
  parameter int unsigned ROWS    = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tdcp_cmd_if.sink      cmd_i,
  tdcp_reply_if.source  reply_o
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COL_OFS   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] IDX_ONE   = ADDR_W'(1);
  localparam logic [16:0]       CELLS_W   = 17'(CELLS);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [15:0]       cursor_q, cursor_d;
  logic              auto_q, auto_d;
  logic [1:0]        port_q, port_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_port_q, out_port_d;
  logic [15:0]       out_value_q, out_value_d;

  logic [7:0]        mem_q [CELLS];
  logic [7:0]        rdata_q;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;

  logic              out_free, accept, in_range, can_adv;

  assign out_free = !out_valid_q || reply_o.ready;
  assign accept   = cmd_i.valid && cmd_i.ready;
  assign in_range = {1'b0, cursor_q} < CELLS_W;
  assign can_adv  = ({1'b0, cursor_q} + 17'd1) < CELLS_W;

  assign cmd_i.ready         = (state_q == ST_IDLE) && out_free;
  assign reply_o.valid       = out_valid_q;
  assign reply_o.reply_port  = out_port_q;
  assign reply_o.reply_value = out_value_q;

  // Character store with one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Control and reply registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      idx_q       <= '0;
      cursor_q    <= '0;
      auto_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cursor_q    <= cursor_d;
      auto_q      <= auto_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Reply payload and pending port need no reset.
  always_ff @(posedge clk_i) begin
    port_q      <= port_d;
    out_port_q  <= out_port_d;
    out_value_q <= out_value_d;
  end

  // Sequencer: decodes requests and walks the store for clearing and scrolling.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cursor_d    = cursor_q;
    auto_d      = auto_q;
    port_d      = port_q;
    out_valid_d = out_valid_q && !reply_o.ready;
    out_port_d  = out_port_q;
    out_value_d = out_value_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_q;
    raddr       = cursor_q[ADDR_W-1:0];
    wdata       = SPACE_CHAR;

    case (state_q)
      ST_FILL: begin
        we    = 1'b1;
        idx_d = idx_q + IDX_ONE;
        if (idx_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_GET_MODE: begin
              out_valid_d = 1'b1;
              out_port_d  = cmd_i.source_port;
              out_value_d = {15'd0, auto_q};
            end
            CMD_SET_MODE: begin
              if (cmd_i.data[7:1] == 7'd0) begin
                auto_d = cmd_i.data[0];
              end
            end
            CMD_GET_POS: begin
              out_valid_d = 1'b1;
              out_port_d  = cmd_i.source_port;
              out_value_d = cursor_q;
            end
            CMD_SET_HIGH: cursor_d = {cmd_i.data, cursor_q[7:0]};
            CMD_SET_LOW:  cursor_d = {cursor_q[15:8], cmd_i.data};
            CMD_GET_CHAR: begin
              if (in_range) begin
                re      = 1'b1;
                port_d  = cmd_i.source_port;
                state_d = ST_RD_WAIT;
                if (auto_q && can_adv) begin
                  cursor_d = cursor_q + 16'd1;
                end
              end
            end
            CMD_SET_CHAR: begin
              if (in_range) begin
                we    = 1'b1;
                waddr = cursor_q[ADDR_W-1:0];
                wdata = cmd_i.data;
                if (auto_q && can_adv) begin
                  cursor_d = cursor_q + 16'd1;
                end
              end
            end
            CMD_SCROLL: begin
              idx_d   = '0;
              state_d = ST_SCR_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_port_d  = port_q;
          out_value_d = {8'd0, rdata_q};
          state_d     = ST_IDLE;
        end
      end
      ST_SCR_RD: begin
        // Fetch the cell one row below the destination.
        re      = 1'b1;
        raddr   = idx_q + COL_OFS;
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
        idx_d = idx_q + IDX_ONE;
        if (idx_q == LAST_MOVE) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_SCR_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/tdcp_checker.sv
// Port-level assertions for the text display command port.
// Depends on tdcp_pkg; bound to text_display_command_port below.
module tdcp_checker
  import tdcp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic [7:0]  cmd_command_i,
  input logic [1:0]  cmd_source_port_i,
  input logic        reply_valid_i,
  input logic        reply_ready_i,
  input logic [1:0]  reply_port_i,
  input logic [15:0] reply_value_i
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  // A stalled reply stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && !reply_ready_i |=> reply_valid_i)
    else $error("reply dropped while stalled");

  // A mode or position read replies in the next cycle to its source port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_command_i == CMD_GET_MODE || cmd_command_i == CMD_GET_POS)
    |=> reply_valid_i && reply_port_i == $past(cmd_source_port_i))
    else $error("register read reply missing or misrouted");

  // The mode reply is a single bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_command_i == CMD_GET_MODE |=> reply_value_i[15:1] == 15'd0)
    else $error("mode reply out of range");

  // A scroll holds off the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_command_i == CMD_SCROLL |=> !cmd_ready_i)
    else $error("request taken during scroll");

endmodule

bind text_display_command_port tdcp_checker u_tdcp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cmd_valid_i       (cmd_i.valid),
  .cmd_ready_i       (cmd_i.ready),
  .cmd_command_i     (cmd_i.command),
  .cmd_source_port_i (cmd_i.source_port),
  .reply_valid_i     (reply_o.valid),
  .reply_ready_i     (reply_o.ready),
  .reply_port_i      (reply_o.reply_port),
  .reply_value_i     (reply_o.reply_value)
);
